FILE: hdl/scba_pkg.sv
// Shared types and default sizes for the size-class bitmap allocator.
// No dependencies; imported by size_class_bitmap_allocator.
`timescale 1ns / 1ps
`default_nettype none

package scba_pkg;

  // Default sizing, handed to the top level as parameter defaults.
  localparam int SlotsPerPoolDef = 32;
  localparam int MinSizeIndexDef = 2;
  localparam int PoolCountDef    = 16;

  localparam int DataWidth   = 32;
  localparam int SizeWidth   = 16;
  localparam int StatusWidth = 3;
  localparam int ReqWidth    = 2;
  localparam int PaddrWidth  = 3;

  // Register word index on the configuration port.
  localparam logic RegArenaBase = 1'b0;

  typedef enum logic [ReqWidth-1:0] {
    REQ_CREATE  = 2'd0,
    REQ_ALLOC   = 2'd1,
    REQ_DEALLOC = 2'd2,
    REQ_DESTROY = 2'd3
  } req_e;

  typedef enum logic [StatusWidth-1:0] {
    STAT_OK          = 3'd0,
    STAT_BAD_SIZE    = 3'd1,
    STAT_NOT_CREATED = 3'd2,
    STAT_FULL        = 3'd3,
    STAT_NO_POOL     = 3'd4,
    STAT_BAD_ADDR    = 3'd5
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

endpackage

`default_nettype wire

FILE: hdl/size_class_bitmap_allocator.sv
// Size-class bitmap allocator: one pool per power-of-two object size, one
// occupancy word per pool held in a synchronous memory. Depends on scba_pkg.
//
// Usage:
//   Requests arrive on the input channel (in_valid_i / in_stall_o) with
//   req_type_i, obj_size_i and address_i. Each request gives exactly one
//   result beat on the output channel (out_valid_o / out_stall_i) carrying
//   status_o and obj_address_o.
//   For each request the accept edge decodes the size or the address
//   into a pool index and reads that pool's bitmap word; in the EXEC
//   state, once the output register is free, the word is modified and
//   written back and the result register is loaded. The single bitmap
//   memory port does one read-modify-write per request, not overlapped.
//   A result waits in the output register while the receiver stalls; the
//   next request is still accepted, and its write-back holds until the
//   output register is free.
//   Reset clears the pool-present flags, the base register and the output
//   valid. The bitmap memory needs no clearing: a word is only used for a
//   present pool, and creating a pool writes its word to zero. The user
//   writes the arena base over the APB-style port at byte address 0 only
//   while the block is idle (not enforced); pready is always high.
`timescale 1ns / 1ps
`default_nettype none

module size_class_bitmap_allocator #(
  parameter int SLOTS_PER_POOL = scba_pkg::SlotsPerPoolDef,
  parameter int MIN_SIZE_INDEX = scba_pkg::MinSizeIndexDef,
  parameter int POOL_COUNT     = scba_pkg::PoolCountDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [scba_pkg::PaddrWidth-1:0]     paddr,
  input  wire logic [scba_pkg::DataWidth-1:0]      pwdata,
  output logic      [scba_pkg::DataWidth-1:0]      prdata,
  output logic                                     pready,
  // request channel
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [scba_pkg::ReqWidth-1:0]       req_type_i,
  input  wire logic [scba_pkg::SizeWidth-1:0]      obj_size_i,
  input  wire logic [scba_pkg::DataWidth-1:0]      address_i,
  // result channel
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic      [scba_pkg::StatusWidth-1:0]    status_o,
  output logic      [scba_pkg::DataWidth-1:0]      obj_address_o
);
  import scba_pkg::*;

  localparam int PW = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
  localparam int SW = (SLOTS_PER_POOL > 1) ? $clog2(SLOTS_PER_POOL) : 1;

  // Configuration register
  logic [DataWidth-1:0] arena_q;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegArenaBase);
  assign prdata = (paddr[2] == RegArenaBase) ? arena_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_q <= '0;
    end else if (cfg_wr) begin
      arena_q <= pwdata;
    end
  end

  // Control state
  state_e                state_q, state_d;
  logic                  accept;
  logic                  exec_fire;
  logic [POOL_COUNT-1:0] present_q;
  logic                  out_valid_q;

  // Request held between decode and write-back
  req_e                  op_q;
  status_e               pre_stat_q;
  logic [PW-1:0]         pool_q;
  logic [SW-1:0]         slot_q;
  logic [DataWidth-1:0]  base_q;

  // Bitmap memory
  logic [SLOTS_PER_POOL-1:0] bitmap_mem [POOL_COUNT];
  logic [SLOTS_PER_POOL-1:0] rd_data_q;
  logic                      mem_we;
  logic [SLOTS_PER_POOL-1:0] mem_wdata;

  // Decode of the incoming request
  req_e                  req_in;
  logic [DataWidth-1:0]  region_start [POOL_COUNT];
  logic [DataWidth-1:0]  offset;
  logic [POOL_COUNT-1:0] size_hit;
  logic [POOL_COUNT-1:0] addr_hit;
  logic [PW-1:0]         size_pool;
  logic [PW-1:0]         addr_pool;
  logic [SW-1:0]         addr_slot;
  logic [DataWidth-1:0]  size_base;
  logic [PW-1:0]         pool_d;
  status_e               pre_stat_d;

  assign req_in = req_e'(req_type_i);
  assign offset = address_i - arena_q;

  always_comb begin
    size_hit  = '0;
    addr_hit  = '0;
    size_pool = '0;
    addr_pool = '0;
    addr_slot = '0;
    size_base = '0;
    for (int k = 0; k < POOL_COUNT; k++) begin
      region_start[k] = DataWidth'(SLOTS_PER_POOL) << k;
      // Regions are disjoint and adjacent, so at most one pool matches.
      addr_hit[k] = present_q[k] && (offset >= region_start[k]) &&
                    (offset < (region_start[k] << 1));
      // A size matches only an exact power of two in the pool range.
      size_hit[k] = (k >= MIN_SIZE_INDEX) &&
                    (DataWidth'(obj_size_i) == (DataWidth'(1) << k));
      if (size_hit[k]) begin
        size_pool = PW'(k);
        size_base = arena_q + region_start[k];
      end
      if (addr_hit[k]) begin
        addr_pool = PW'(k);
        addr_slot = SW'((offset - region_start[k]) >> k);
      end
    end
  end

  always_comb begin
    pre_stat_d = STAT_OK;
    pool_d     = size_pool;
    unique case (req_in)
      REQ_DEALLOC: begin
        pool_d = addr_pool;
        if (address_i == '0) begin
          pre_stat_d = STAT_BAD_ADDR;
        end else if (addr_hit == '0) begin
          pre_stat_d = STAT_NO_POOL;
        end
      end
      REQ_CREATE: begin
        if (size_hit == '0) begin
          pre_stat_d = STAT_BAD_SIZE;
        end
      end
      REQ_ALLOC: begin
        if (size_hit == '0) begin
          pre_stat_d = STAT_BAD_SIZE;
        end else if (!present_q[size_pool]) begin
          pre_stat_d = STAT_NOT_CREATED;
        end
      end
      REQ_DESTROY: begin
        if (size_hit == '0) begin
          pre_stat_d = STAT_BAD_SIZE;
        end else if (!present_q[size_pool]) begin
          pre_stat_d = STAT_NO_POOL;
        end
      end
      default: pre_stat_d = STAT_BAD_SIZE;
    endcase
  end

  // Sequencer: accept in IDLE, write back in EXEC once the output is free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    accept     = 1'b0;
    exec_fire  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        accept     = in_valid_i;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        // Hold while a previous result still waits on the receiver.
        if (!(out_valid_q && out_stall_i)) begin
          exec_fire = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Capture the decoded request and read its bitmap word.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= req_in;
      pre_stat_q <= pre_stat_d;
      pool_q     <= pool_d;
      slot_q     <= addr_slot;
      base_q     <= size_base;
      rd_data_q  <= bitmap_mem[pool_d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bitmap_mem[pool_q] <= mem_wdata;
    end
  end

  // Modify step
  logic [SLOTS_PER_POOL-1:0] free_bits;
  logic [SW-1:0]             free_idx;
  logic [SLOTS_PER_POOL-1:0] alloc_bit;
  logic [SLOTS_PER_POOL-1:0] dealloc_bit;
  status_e                   res_stat;
  logic [DataWidth-1:0]      res_addr;
  logic                      set_present;
  logic                      clr_present;

  assign free_bits   = ~rd_data_q;
  assign alloc_bit   = SLOTS_PER_POOL'(1) << free_idx;
  assign dealloc_bit = SLOTS_PER_POOL'(1) << slot_q;

  // Lowest free slot
  always_comb begin
    free_idx = '0;
    for (int s = SLOTS_PER_POOL - 1; s >= 0; s--) begin
      if (free_bits[s]) begin
        free_idx = SW'(s);
      end
    end
  end

  always_comb begin
    res_stat    = pre_stat_q;
    res_addr    = '0;
    mem_we      = 1'b0;
    mem_wdata   = rd_data_q;
    set_present = 1'b0;
    clr_present = 1'b0;
    if (pre_stat_q == STAT_OK) begin
      case (op_q)
        REQ_CREATE: begin
          // Existing pool keeps its bitmap.
          if (!present_q[pool_q]) begin
            set_present = 1'b1;
            mem_we      = exec_fire;
            mem_wdata   = '0;
          end
        end
        REQ_ALLOC: begin
          if (free_bits == '0) begin
            res_stat = STAT_FULL;
          end else begin
            mem_we    = exec_fire;
            mem_wdata = rd_data_q | alloc_bit;
            res_addr  = base_q + (DataWidth'(free_idx) << pool_q);
          end
        end
        REQ_DEALLOC: begin
          if ((rd_data_q & dealloc_bit) == '0) begin
            res_stat = STAT_BAD_ADDR;
          end else begin
            mem_we    = exec_fire;
            mem_wdata = rd_data_q & ~dealloc_bit;
          end
        end
        default: begin
          // Destroy: the word is rewritten on the next create.
          clr_present = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
    end else if (exec_fire) begin
      if (set_present) begin
        present_q[pool_q] <= 1'b1;
      end else if (clr_present) begin
        present_q[pool_q] <= 1'b0;
      end
    end
  end

  // Output register
  logic [StatusWidth-1:0] status_q;
  logic [DataWidth-1:0]   alloc_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      status_q     <= res_stat;
      alloc_addr_q <= res_addr;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign obj_address_o = alloc_addr_q;

endmodule

`default_nettype wire
